FILE: src/hfu8_pkg.sv
// ----------------------------------------------------------------------------
// hfu8_pkg
// shared types and constants for the half float to unorm8 pixel converter
// ----------------------------------------------------------------------------
package hfu8_pkg;

    localparam int CHAN_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int NUM_CHAN = 4;
    localparam int EXP_W    = 5;
    localparam int MANT_W   = 10;
    localparam int SIG_W    = MANT_W + 1;
    localparam int PROD_W   = SIG_W + BYTE_W;
    localparam int SHIFT_W  = 4;
    localparam int SUM_W    = 34;
    localparam int FRAC_LSB = 25;

    localparam logic [EXP_W-1:0]  EXP_MAX   = 5'h1F;
    localparam logic [EXP_W-1:0]  EXP_ONE   = 5'h0F;
    localparam logic [EXP_W-1:0]  EXP_ZERO  = 5'h00;
    localparam logic [MANT_W-1:0] MANT_ZERO = 10'h000;
    localparam logic [SUM_W-1:0]  ROUND_BIAS = 34'h0_0100_0000;
    localparam logic [BYTE_W-1:0] BYTE_MAX  = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_MIN  = 8'h00;

    typedef logic [NUM_CHAN*CHAN_W-1:0] pixel_in_t;
    typedef logic [NUM_CHAN*BYTE_W-1:0] pixel_out_t;

endpackage

FILE: src/half_float_to_unorm8_pixel.sv
// ----------------------------------------------------------------------------
// half_float_to_unorm8_pixel
// four-channel binary16 or byte pixel to rgba8 unorm converter
//
//   channel   direction  width  content (low bit up)
//   s_axis    in         64     chan_0, chan_1, chan_2, chan_3
//   m_axis    out        32     red_byte, green_byte, blue_byte, alpha_byte
//   cfg       in         1      half_mode
//
// one pixel per clock sustained while m_axis is ready; an input beat passes
// through an input register, the per-channel conversion and a result register.
// reset clears the valid flags and sets half_mode to 0.
// a stall on m_axis backs up through both registers; each register reloads
// in the cycle it drains, so no bubble is added.
// ----------------------------------------------------------------------------
module half_float_to_unorm8_pixel
    import hfu8_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration write
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_data,       // half_mode
    // pixel input
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [NUM_CHAN*CHAN_W-1:0] s_axis_tdata,   // chan_0, chan_1, chan_2, chan_3
    // pixel output
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [NUM_CHAN*BYTE_W-1:0] m_axis_tdata    // red, green, blue, alpha bytes
);

    logic       half_mode_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    pixel_in_t  in_data_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    pixel_out_t out_data_reg;
    pixel_out_t conv_data;
    logic       out_load;
    logic       in_load;

    // configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            half_mode_reg <= cfg_data;
        end
    end

    // pipeline flow control
    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign in_load       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_load;

    assign in_valid_next  = in_load || (in_valid_reg && !out_load);
    assign out_valid_next = out_load || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_data_reg <= s_axis_tdata;
        end
    end

    // per-channel conversion
    for (genvar i = 0; i < NUM_CHAN; i++)
    begin : g_chan
        hfu8_chan_conv u_conv (
            .half_mode (half_mode_reg),
            .chan      (in_data_reg[i*CHAN_W +: CHAN_W]),
            .unorm     (conv_data[i*BYTE_W +: BYTE_W])
        );
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= conv_data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: src/hfu8_chan_conv.sv
// ----------------------------------------------------------------------------
// hfu8_chan_conv
// converts one 16-bit channel to an unsigned normalized byte
// ----------------------------------------------------------------------------
module hfu8_chan_conv
    import hfu8_pkg::*;
(
    input  logic              half_mode,
    input  logic [CHAN_W-1:0] chan,
    output logic [BYTE_W-1:0] unorm
);

    logic                 sign;
    logic [EXP_W-1:0]     expo;
    logic [MANT_W-1:0]    mant;
    logic [SIG_W-1:0]     sig;
    logic [SHIFT_W-1:0]   shamt;
    logic [PROD_W-1:0]    prod;
    logic [SUM_W-1:0]     shifted;
    logic [SUM_W-1:0]     sum;
    logic [BYTE_W-1:0]    frac;

    // field split
    assign sign = chan[CHAN_W-1];
    assign expo = chan[CHAN_W-2 -: EXP_W];
    assign mant = chan[MANT_W-1:0];

    // significand and scale, subnormals use the smallest normal scale
    assign sig   = (expo == EXP_ZERO) ? {1'b0, mant} : {1'b1, mant};
    assign shamt = (expo == EXP_ZERO) ? SHIFT_W'(1) : expo[SHIFT_W-1:0];

    // times 255 as shift and subtract, then scale and round half up
    assign prod    = {sig, BYTE_MIN} - {{BYTE_W{1'b0}}, sig};
    assign shifted = {{(SUM_W-PROD_W){1'b0}}, prod} << shamt;
    assign sum     = shifted + ROUND_BIAS;
    assign frac    = sum[FRAC_LSB +: BYTE_W];

    // special cases and byte pass-through
    always_comb
    begin
        if (!half_mode)
        begin
            unorm = chan[BYTE_W-1:0];
        end
        else if (expo == EXP_MAX)
        begin
            // nan and negative infinity give zero, positive infinity saturates
            unorm = (mant != MANT_ZERO || sign) ? BYTE_MIN : BYTE_MAX;
        end
        else if (sign)
        begin
            unorm = BYTE_MIN;
        end
        else if (expo >= EXP_ONE)
        begin
            unorm = BYTE_MAX;
        end
        else
        begin
            unorm = frac;
        end
    end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// regression for the half float to unorm8 pixel converter
//
// a clocked driver offers pixel beats from a queue that the stimulus process
// fills; each accepted beat is converted by a local predictor under the mode
// last written and queued. a clocked monitor compares every output beat byte
// by byte with the oldest queued pixel. the mode is only changed once the
// pipeline has drained. both sides idle at random; once the receiver holds
// off for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module testbench
    import hfu8_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PHASES   = 6;
    localparam int PIXELS_PER_PHASE = 250;
    localparam int IDLE_PCT_NORMAL = 31;
    localparam int HOLD_AFTER_BEATS = 400;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 4;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_data = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    pixel_in_t        s_axis_tdata = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    pixel_out_t       m_axis_tdata;

    // stimulus and scoreboard storage
    pixel_in_t        pending_px [$];
    pixel_out_t       expected_px [$];
    bit               half_mode_now = 1'b0;
    int               idle_pct = IDLE_PCT_NORMAL;
    int               error_count = 0;
    int unsigned      beats_in = 0;
    int unsigned      hold_left = 0;
    bit               hold_done = 1'b0;

    string byte_name [NUM_CHAN] = '{"red", "green", "blue", "alpha"};

    half_float_to_unorm8_pixel u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // binary16 to unorm8, exact scale by 255 with round half up
    function automatic logic [BYTE_W-1:0] half_to_unorm8(input logic [CHAN_W-1:0] h);
        logic              sgn;
        logic [EXP_W-1:0]  e;
        logic [MANT_W-1:0] m;
        logic [63:0]       sig;
        logic [63:0]       acc;
        int unsigned       k;
        sgn = h[CHAN_W-1];
        e   = h[MANT_W +: EXP_W];
        m   = h[MANT_W-1:0];
        // nan and infinities
        if (e == EXP_MAX)
            return (m != MANT_ZERO || sgn) ? BYTE_MIN : BYTE_MAX;
        // negatives and negative zero
        if (sgn)
            return BYTE_MIN;
        // one or more saturates
        if (e >= EXP_ONE)
            return BYTE_MAX;
        if (e == EXP_ZERO)
        begin
            sig = 64'(m);
            k   = 1;
        end
        else
        begin
            sig = 64'({1'b1, m});
            k   = e;
        end
        acc = ((64'd255 * sig) << k) + (64'd1 << 24);
        return acc[32:25];
    endfunction

    // whole pixel under the given mode
    function automatic pixel_out_t convert_pixel(input pixel_in_t px, input bit half);
        pixel_out_t       res;
        logic [CHAN_W-1:0] ch;
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            ch = px[i*CHAN_W +: CHAN_W];
            res[i*BYTE_W +: BYTE_W] = half ? half_to_unorm8(ch) : ch[BYTE_W-1:0];
        end
        return res;
    endfunction

    function automatic pixel_in_t make_pixel(input logic [CHAN_W-1:0] c0, c1, c2, c3);
        return {c3, c2, c1, c0};
    endfunction

    // random channel: in half mode half the values inside [0,1), the rest any pattern or specials
    function automatic logic [CHAN_W-1:0] random_channel(input bit half);
        logic [CHAN_W-1:0] specials [8] = '{16'h0000, 16'h8000, 16'h3C00, 16'h7C00,
                                            16'hFC00, 16'h7E01, 16'h3BFF, 16'h0001};
        int unsigned pick;
        if (!half)
            return CHAN_W'($urandom_range(65535, 0));
        pick = $urandom_range(9, 0);
        if (pick < 4)
            return CHAN_W'($urandom_range(65535, 0));
        if (pick < 9)
            return {1'b0, EXP_W'($urandom_range(14, 0)), MANT_W'($urandom)};
        return specials[$urandom_range(7, 0)];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // write half_mode and track it for the predictor
    task automatic set_half_mode(input bit mode);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        half_mode_now = mode;
        cfg_valid <= 1'b0;
    endtask

    // wait until every queued pixel has been sent and checked
    task automatic drain_pixels();
        while (pending_px.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_px.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // pixel driver: offer the next beat once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_px.push_back(convert_pixel(s_axis_tdata, half_mode_now));
                beats_in <= beats_in + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_px.size() != 0 && $urandom_range(99, 0) >= idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_px.pop_front();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off partway through the run
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && beats_in >= HOLD_AFTER_BEATS)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // receiver ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99, 0) >= idle_pct);
    end

    // output monitor: compare each beat with the oldest expected pixel
    always @(posedge clk)
    begin : pixel_monitor
        pixel_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_px.size() == 0)
                report_mismatch($sformatf("output beat %h with no pixel expected",
                                          m_axis_tdata));
            else
            begin
                want = expected_px.pop_front();
                for (int i = 0; i < NUM_CHAN; i++)
                    if (m_axis_tdata[i*BYTE_W +: BYTE_W] !== want[i*BYTE_W +: BYTE_W])
                        report_mismatch($sformatf("%s_byte got %h expected %h",
                                                  byte_name[i],
                                                  m_axis_tdata[i*BYTE_W +: BYTE_W],
                                                  want[i*BYTE_W +: BYTE_W]));
            end
        end
    end

    // reset, mode phases and stimulus
    initial
    begin
        static bit phase_mode [RANDOM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // byte mode: high bytes must be dropped
        set_half_mode(1'b0);
        pending_px.push_back(make_pixel(16'h0000, 16'hFFFF, 16'hFF00, 16'h00FF));
        pending_px.push_back(make_pixel(16'hA55A, 16'h5AA5, 16'h0080, 16'h7F01));
        drain_pixels();

        // half mode: zeros, subnormals, rounding ties, saturation, nan
        set_half_mode(1'b1);
        pending_px.push_back(make_pixel(16'h0000, 16'h8000, 16'h0001, 16'h03FF));
        pending_px.push_back(make_pixel(16'h0400, 16'h3BFF, 16'h3C00, 16'h3800));
        pending_px.push_back(make_pixel(16'h7BFF, 16'h7C00, 16'hFC00, 16'h7E00));
        pending_px.push_back(make_pixel(16'hFFFF, 16'h7C01, 16'hBC00, 16'h2C00));
        pending_px.push_back(make_pixel(16'h1C00, 16'h3555, 16'h3BFE, 16'h0200));
        drain_pixels();

        // random phases, one of them with no idling on either side
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_half_mode(phase_mode[p]);
            idle_pct = (p == 2) ? 0 : IDLE_PCT_NORMAL;
            for (int n = 0; n < PIXELS_PER_PHASE; n++)
                pending_px.push_back(make_pixel(random_channel(phase_mode[p]),
                                                random_channel(phase_mode[p]),
                                                random_channel(phase_mode[p]),
                                                random_channel(phase_mode[p])));
            drain_pixels();
        end

        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_px.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
